### rtl/energy_voice_activity_detector_core_macros.svh
// ----------------------------------------------------------------------------
// evad assertion macros
// shared property templates for the detector checks
// ----------------------------------------------------------------------------
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_CORE_MACROS_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_CORE_MACROS_SVH

// same-cycle implication
`define EVAD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("evad check failed");

// next-cycle implication
`define EVAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("evad check failed");

`endif

### rtl/evad_pkg.sv
// ----------------------------------------------------------------------------
// evad package
// shared types, codes and constants of the voice activity detector
// ----------------------------------------------------------------------------
package evad_pkg;

   localparam int MAX_FRAME_DEF  = 4096;
   localparam int CAL_FRAMES_DEF = 16;

   localparam int ModeW = 3;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 16;

   localparam logic [15:0] THR_MIN       = 16'd197;
   localparam logic [15:0] THR_MAX       = 16'd1311;
   localparam logic [15:0] INIT_THR_RST  = 16'd655;
   localparam logic [6:0]  CAL_GAIN_RST  = 7'd40;
   localparam logic [6:0]  PLAY_GAIN_RST = 7'd48;
   localparam logic [6:0]  CAL_GAIN_MIN  = 7'd24;
   localparam logic [6:0]  CAL_GAIN_MAX  = 7'd64;
   localparam logic [6:0]  PLAY_GAIN_MIN = 7'd32;
   localparam logic [6:0]  PLAY_GAIN_MAX = 7'd80;
   localparam logic [3:0]  START_NEED_NORMAL = 4'd1;
   localparam logic [3:0]  END_NEED_NORMAL   = 4'd12;
   localparam logic [3:0]  START_NEED_PLAY   = 4'd10;
   localparam logic [3:0]  END_NEED_PLAY     = 4'd5;
   localparam logic [6:0]  CAL_WRAP_FRAMES   = 7'd64;

   typedef enum logic [ModeW-1:0] {
      MODE_SAMPLE     = 3'd0,
      MODE_CAL_START  = 3'd1,
      MODE_PLAY_START = 3'd2,
      MODE_PLAY_END   = 3'd3,
      MODE_CLEAR      = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_START = 2'd1,
      ACT_END   = 2'd2
   } activity_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_INIT_THR  = 2'd0,
      CSR_CAL_GAIN  = 2'd1,
      CSR_PLAY_GAIN = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIV,
      ST_ROOT,
      ST_FRAME,
      ST_CAL_DIV,
      ST_CAL_BASE,
      ST_CAL_ACTIVE,
      ST_EMIT
   } state_type;

   // handshake between the sequencer and a serial unit
   typedef struct packed {
      logic start;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

### rtl/evad_req_if.sv
// ----------------------------------------------------------------------------
// evad request channel
// valid/ready channel carrying one audio or control beat
// ----------------------------------------------------------------------------
interface evad_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [15:0] sample;
   logic        last_sample;

   modport source (output valid, mode, sample, last_sample, input ready);
   modport sink (input valid, mode, sample, last_sample, output ready);
endinterface

### rtl/evad_rsp_if.sv
// ----------------------------------------------------------------------------
// evad response channel
// valid/ready channel carrying one frame result beat
// ----------------------------------------------------------------------------
interface evad_rsp_if;
   logic        valid;
   logic        ready;
   logic        voiced;
   logic        speech_active;
   logic [1:0]  activity;
   logic [15:0] energy;
   logic [15:0] threshold;
   logic        calibrating;

   modport source (output valid, voiced, speech_active, activity, energy, threshold,
                   calibrating, input ready);
   modport sink (input valid, voiced, speech_active, activity, energy, threshold,
                 calibrating, output ready);
endinterface

### rtl/evad_divider.sv
// ----------------------------------------------------------------------------
// evad serial divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module evad_divider #(
   parameter int DvdW = 45,
   parameter int DivW = 13
) (
   input  logic                      clock,
   input  logic                      reset,
   input  evad_pkg::unit_ctl_type    ctl,
   output evad_pkg::unit_sts_type    sts,
   input  logic [DvdW-1:0]           dividend,
   input  logic [DivW-1:0]           divisor,
   output logic [DvdW-1:0]           quotient
);
   import evad_pkg::*;

   localparam int CntW = $clog2(DvdW + 1);

   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            done_ff, done_in;
   logic [DivW-1:0] rem_ff, rem_in;
   logic [DivW-1:0] dsr_ff, dsr_in;
   logic [DvdW-1:0] quo_ff, quo_in;
   logic [DivW:0]   rem_sh;
   logic            busy;

   assign busy = (cnt_ff != '0);
   assign rem_sh = {rem_ff, quo_ff[DvdW-1]};

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      done_in = busy && (cnt_ff == CntW'(1));
      if (busy) begin
         cnt_in = cnt_ff - CntW'(1);
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = DivW'(rem_sh - {1'b0, dsr_ff});
            quo_in = {quo_ff[DvdW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DivW-1:0];
            quo_in = {quo_ff[DvdW-2:0], 1'b0};
         end
      end else if (ctl.start && !done_ff) begin
         cnt_in = CntW'(DvdW);
         rem_in = '0;
         dsr_in = divisor;
         quo_in = dividend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign sts.busy = busy;
   assign sts.done = done_ff;
   assign quotient = quo_ff;
endmodule

### rtl/evad_sqrt.sv
// ----------------------------------------------------------------------------
// evad serial square root
// digit-by-digit integer root, two radicand bits and one root bit per cycle
// ----------------------------------------------------------------------------
module evad_sqrt #(
   parameter int RadW = 45
) (
   input  logic                      clock,
   input  logic                      reset,
   input  evad_pkg::unit_ctl_type    ctl,
   output evad_pkg::unit_sts_type    sts,
   input  logic [RadW-1:0]           radicand,
   output logic [(RadW+1)/2-1:0]     root
);
   import evad_pkg::*;

   localparam int SqW  = 2 * ((RadW + 1) / 2);
   localparam int HalfW = SqW / 2;
   localparam int CntW = $clog2(HalfW + 1);

   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [SqW-1:0]     rad_ff, rad_in;
   logic [HalfW+1:0]   rem_ff, rem_in;
   logic [HalfW-1:0]   root_ff, root_in;
   logic [HalfW+3:0]   rem_t;
   logic [HalfW+3:0]   trial;
   logic               busy;

   assign busy  = (cnt_ff != '0);
   assign rem_t = {rem_ff, rad_ff[SqW-1:SqW-2]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_comb begin
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      done_in = busy && (cnt_ff == CntW'(1));
      if (busy) begin
         cnt_in = cnt_ff - CntW'(1);
         rad_in = {rad_ff[SqW-3:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = (HalfW+2)'(rem_t - trial);
            root_in = {root_ff[HalfW-2:0], 1'b1};
         end else begin
            rem_in  = rem_t[HalfW+1:0];
            root_in = {root_ff[HalfW-2:0], 1'b0};
         end
      end else if (ctl.start && !done_ff) begin
         cnt_in  = CntW'(HalfW);
         rad_in  = SqW'(radicand);
         rem_in  = '0;
         root_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sts.busy = busy;
   assign sts.done = done_ff;
   assign root = root_ff;
endmodule

### rtl/energy_voice_activity_detector_core.sv
// a sample beat without the last mark passes the square and accumulate states before the input is
//   ready again; a frame-ending beat then runs the serial divide, the serial root and the frame
//   update, plus a calibration divide and threshold update when calibration finishes, then emits
// throughput: one beat at a time; a stalled result beat holds the next frame in the emit state;
//   control beats are taken one per cycle
// reset clears all control state, loads the default registers and thresholds, ready at once
// ----------------------------------------------------------------------------
// energy voice activity detector core
// frame energy (twice the rms) by serial divide and root, threshold compare with hysteresis,
// ambient calibration and playback threshold lift
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_core #(
   parameter int MAX_FRAME  = evad_pkg::MAX_FRAME_DEF,
   parameter int CAL_FRAMES = evad_pkg::CAL_FRAMES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   evad_req_if.sink                       req_chan,
   evad_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_en,
   input  logic [evad_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [evad_pkg::CsrDataW-1:0]  csr_write_data
);
   import evad_pkg::*;

   // frame accumulator widths follow the frame length
   localparam int CountW = $clog2(MAX_FRAME + 1);
   localparam int SumW   = 30 + CountW;
   localparam int DvdW   = SumW + 2;
   localparam int DivW   = (CountW > 7) ? CountW : 7;
   localparam int RootW  = (DvdW + 1) / 2;

   state_type state_ff, state_in;

   // configuration registers; the initial threshold lives on in base and active
   logic [6:0]  cal_gain_ff, cal_gain_in;
   logic [6:0]  play_gain_ff, play_gain_in;

   // detector state
   logic [SumW-1:0]   sum_ff, sum_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              speech_ff, speech_in;
   logic [3:0]        start_run_ff, start_run_in;
   logic [3:0]        end_run_ff, end_run_in;
   logic [3:0]        start_need_ff, start_need_in;
   logic [3:0]        end_need_ff, end_need_in;
   logic              play_ff, play_in;
   logic              cal_ff, cal_in;
   logic [5:0]        cal_frames_ff, cal_frames_in;
   logic [21:0]       cal_sum_ff, cal_sum_in;
   logic [15:0]       ambient_ff, ambient_in;
   logic [15:0]       base_ff, base_in;
   logic [15:0]       active_ff, active_in;

   // per-beat working registers
   logic [15:0] mag_ff, mag_in;
   logic        last_ff, last_in;
   logic [31:0] square_ff, square_in;
   logic [15:0] energy_ff, energy_in;
   logic        voiced_ff, voiced_in;
   logic [1:0]  act_ff, act_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_voiced_ff, rsp_voiced_in;
   logic        rsp_speech_ff, rsp_speech_in;
   logic [1:0]  rsp_act_ff, rsp_act_in;
   logic [15:0] rsp_energy_ff, rsp_energy_in;
   logic [15:0] rsp_thr_ff, rsp_thr_in;
   logic        rsp_cal_ff, rsp_cal_in;

   logic req_fire, rsp_free;
   logic [22:0] play_prod, cal_prod;
   logic [21:0] cal_sum_next;
   logic [5:0]  cal_frames_next;
   logic [6:0]  cal_divisor;
   logic [15:0] frame_energy;
   logic        voiced_now;

   unit_ctl_type        div_ctl, root_ctl;
   unit_sts_type        div_sts, root_sts;
   logic [DvdW-1:0]     div_dividend, div_quotient;
   logic [DivW-1:0]     div_divisor;
   logic [RootW-1:0]    root_val;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign play_prod = 23'(base_ff) * 23'(play_gain_ff);
   assign cal_prod  = 23'(ambient_ff) * 23'(cal_gain_ff);
   assign cal_sum_next    = cal_sum_ff + 22'(energy_ff);
   assign cal_frames_next = cal_frames_ff + 6'd1;
   assign cal_divisor = (cal_frames_ff == '0) ? CAL_WRAP_FRAMES : {1'b0, cal_frames_ff};
   assign voiced_now = (energy_ff > active_ff);

   // frame energy (twice the rms) saturates at full scale
   assign frame_energy = (count_ff == '0) ? 16'd0 :
                         ((|root_val[RootW-1:16]) ? 16'hFFFF : root_val[15:0]);

   assign div_dividend = (state_ff == ST_CAL_DIV) ? DvdW'(cal_sum_ff) : {sum_ff, 2'b00};
   assign div_divisor  = (state_ff == ST_CAL_DIV) ? DivW'(cal_divisor) : DivW'(count_ff);
   assign div_ctl.start  = (state_ff == ST_DIV) || (state_ff == ST_CAL_DIV);
   assign root_ctl.start = (state_ff == ST_ROOT);

   evad_divider #(.DvdW(DvdW), .DivW(DivW)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .sts      (div_sts),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient)
   );

   evad_sqrt #(.RadW(DvdW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (root_ctl),
      .sts      (root_sts),
      .radicand (div_quotient),
      .root     (root_val)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_chan.mode == MODE_SAMPLE)) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = last_ff ? ST_DIV : ST_IDLE;
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_sts.done) begin
               state_in = ST_FRAME;
            end
         end
         ST_FRAME: begin
            // calibration ends when the run is long enough or the frame count wraps
            if (cal_ff && ((cal_frames_next >= 6'(CAL_FRAMES)) || (cal_frames_next == '0))) begin
               state_in = ST_CAL_DIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_CAL_DIV: begin
            if (div_sts.done) begin
               state_in = ST_CAL_BASE;
            end
         end
         ST_CAL_BASE:   state_in = ST_CAL_ACTIVE;
         ST_CAL_ACTIVE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cal_gain_in   = cal_gain_ff;
      play_gain_in  = play_gain_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      speech_in     = speech_ff;
      start_run_in  = start_run_ff;
      end_run_in    = end_run_ff;
      start_need_in = start_need_ff;
      end_need_in   = end_need_ff;
      play_in       = play_ff;
      cal_in        = cal_ff;
      cal_frames_in = cal_frames_ff;
      cal_sum_in    = cal_sum_ff;
      ambient_in    = ambient_ff;
      base_in       = base_ff;
      active_in     = active_ff;
      mag_in        = mag_ff;
      last_in       = last_ff;
      square_in     = square_ff;
      energy_in     = energy_ff;
      voiced_in     = voiced_ff;
      act_in        = act_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_voiced_in = rsp_voiced_ff;
      rsp_speech_in = rsp_speech_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_energy_in = rsp_energy_ff;
      rsp_thr_in    = rsp_thr_ff;
      rsp_cal_in    = rsp_cal_ff;

      // register writes must arrive only while idle; the user keeps to this, the block does not enforce it
      if (csr_write_en) begin
         case (csr_index)
            CSR_INIT_THR: begin
               base_in     = csr_write_data[15:0];
               active_in   = csr_write_data[15:0];
            end
            CSR_CAL_GAIN: begin
               cal_gain_in = (csr_write_data[6:0] < CAL_GAIN_MIN) ? CAL_GAIN_MIN :
                             ((csr_write_data[6:0] > CAL_GAIN_MAX) ? CAL_GAIN_MAX :
                              csr_write_data[6:0]);
            end
            CSR_PLAY_GAIN: begin
               play_gain_in = (csr_write_data[6:0] < PLAY_GAIN_MIN) ? PLAY_GAIN_MIN :
                              ((csr_write_data[6:0] > PLAY_GAIN_MAX) ? PLAY_GAIN_MAX :
                               csr_write_data[6:0]);
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.mode)
                  MODE_SAMPLE: begin
                     mag_in  = req_chan.sample[15] ? 16'(-req_chan.sample) : req_chan.sample;
                     last_in = req_chan.last_sample;
                  end
                  MODE_CAL_START: begin
                     cal_in        = 1'b1;
                     cal_frames_in = '0;
                     cal_sum_in    = '0;
                     ambient_in    = '0;
                  end
                  MODE_PLAY_START: begin
                     play_in       = 1'b1;
                     active_in     = (play_prod[22:4] > 19'(THR_MAX)) ? THR_MAX :
                                     play_prod[19:4];
                     start_need_in = START_NEED_PLAY;
                     end_need_in   = END_NEED_PLAY;
                  end
                  MODE_PLAY_END: begin
                     play_in       = 1'b0;
                     active_in     = base_ff;
                     start_need_in = START_NEED_NORMAL;
                     end_need_in   = END_NEED_NORMAL;
                  end
                  MODE_CLEAR: begin
                     speech_in     = 1'b0;
                     start_run_in  = '0;
                     end_run_in    = '0;
                     cal_in        = 1'b0;
                     cal_frames_in = '0;
                     cal_sum_in    = '0;
                     ambient_in    = '0;
                     active_in     = base_ff;
                     sum_in        = '0;
                     count_in      = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SQUARE: square_in = 32'(mag_ff) * 32'(mag_ff);
         ST_ACCUM: begin
            // samples past the frame limit are dropped, the last mark still counts
            if (32'(count_ff) < 32'(MAX_FRAME)) begin
               sum_in   = sum_ff + SumW'(square_ff);
               count_in = count_ff + CountW'(1);
            end
         end
         ST_ROOT: begin
            if (root_sts.done) begin
               energy_in = frame_energy;
            end
         end
         ST_FRAME: begin
            sum_in    = '0;
            count_in  = '0;
            voiced_in = 1'b0;
            act_in    = ACT_NONE;
            if (cal_ff) begin
               cal_sum_in    = cal_sum_next;
               cal_frames_in = cal_frames_next;
            end else begin
               voiced_in = voiced_now;
               if (voiced_now) begin
                  end_run_in = '0;
                  if (!speech_ff) begin
                     if ((start_run_ff + 4'd1) >= start_need_ff) begin
                        speech_in    = 1'b1;
                        start_run_in = '0;
                        act_in       = ACT_START;
                     end else begin
                        start_run_in = start_run_ff + 4'd1;
                     end
                  end
               end else begin
                  start_run_in = '0;
                  if (speech_ff) begin
                     if ((end_run_ff + 4'd1) >= end_need_ff) begin
                        speech_in  = 1'b0;
                        end_run_in = '0;
                        act_in     = ACT_END;
                     end else begin
                        end_run_in = end_run_ff + 4'd1;
                     end
                  end
               end
            end
         end
         ST_CAL_DIV: begin
            if (div_sts.done) begin
               ambient_in = div_quotient[15:0];
            end
         end
         ST_CAL_BASE: begin
            base_in = (cal_prod[22:4] < 19'(THR_MIN)) ? THR_MIN :
                      ((cal_prod[22:4] > 19'(THR_MAX)) ? THR_MAX : cal_prod[19:4]);
         end
         ST_CAL_ACTIVE: begin
            active_in = play_ff ? play_prod[19:4] : base_ff;
            cal_in    = 1'b0;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_voiced_in = voiced_ff;
               rsp_speech_in = speech_ff;
               rsp_act_in    = act_ff;
               rsp_energy_in = energy_ff;
               rsp_thr_in    = active_ff;
               rsp_cal_in    = cal_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cal_gain_ff   <= CAL_GAIN_RST;
         play_gain_ff  <= PLAY_GAIN_RST;
         sum_ff        <= '0;
         count_ff      <= '0;
         speech_ff     <= 1'b0;
         start_run_ff  <= '0;
         end_run_ff    <= '0;
         start_need_ff <= START_NEED_NORMAL;
         end_need_ff   <= END_NEED_NORMAL;
         play_ff       <= 1'b0;
         cal_ff        <= 1'b0;
         cal_frames_ff <= '0;
         cal_sum_ff    <= '0;
         ambient_ff    <= '0;
         base_ff       <= INIT_THR_RST;
         active_ff     <= INIT_THR_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cal_gain_ff   <= cal_gain_in;
         play_gain_ff  <= play_gain_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         speech_ff     <= speech_in;
         start_run_ff  <= start_run_in;
         end_run_ff    <= end_run_in;
         start_need_ff <= start_need_in;
         end_need_ff   <= end_need_in;
         play_ff       <= play_in;
         cal_ff        <= cal_in;
         cal_frames_ff <= cal_frames_in;
         cal_sum_ff    <= cal_sum_in;
         ambient_ff    <= ambient_in;
         base_ff       <= base_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mag_ff        <= mag_in;
      last_ff       <= last_in;
      square_ff     <= square_in;
      energy_ff     <= energy_in;
      voiced_ff     <= voiced_in;
      act_ff        <= act_in;
      rsp_voiced_ff <= rsp_voiced_in;
      rsp_speech_ff <= rsp_speech_in;
      rsp_act_ff    <= rsp_act_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_thr_ff    <= rsp_thr_in;
      rsp_cal_ff    <= rsp_cal_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.voiced        = rsp_voiced_ff;
   assign rsp_chan.speech_active = rsp_speech_ff;
   assign rsp_chan.activity      = rsp_act_ff;
   assign rsp_chan.energy        = rsp_energy_ff;
   assign rsp_chan.threshold     = rsp_thr_ff;
   assign rsp_chan.calibrating   = rsp_cal_ff;
endmodule

### rtl/evad_checker.sv
// ----------------------------------------------------------------------------
// evad port checker
// port-level checks of the detector, bound to the top level
// ----------------------------------------------------------------------------
`include "energy_voice_activity_detector_core_macros.svh"

module evad_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_voiced,
   input logic        rsp_speech_active,
   input logic [1:0]  rsp_activity,
   input logic [15:0] rsp_energy,
   input logic        rsp_calibrating
);
   import evad_pkg::*;

   // a stalled result beat holds
   `EVAD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_energy))

   // a sample beat occupies the block for the next cycle
   `EVAD_ASSERT_NEXT(a_sample_busy, clock, reset,
                     req_valid && req_ready && (req_mode == MODE_SAMPLE), !req_ready)

   // calibration frames never vote
   `EVAD_ASSERT_NOW(a_cal_silent, clock, reset, rsp_valid && rsp_calibrating,
                    !rsp_voiced && (rsp_activity == ACT_NONE))

   // a reported transition agrees with the speech state
   `EVAD_ASSERT_NOW(a_act_state, clock, reset, rsp_valid && (rsp_activity != ACT_NONE),
                    (rsp_activity == ACT_START && rsp_speech_active) || (rsp_activity == ACT_END && !rsp_speech_active))
endmodule

bind energy_voice_activity_detector_core evad_checker u_evad_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_mode          (req_chan.mode),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_voiced        (rsp_chan.voiced),
   .rsp_speech_active (rsp_chan.speech_active),
   .rsp_activity      (rsp_chan.activity),
   .rsp_energy        (rsp_chan.energy),
   .rsp_calibrating   (rsp_chan.calibrating)
);

### tb/sv/energy_voice_activity_detector_core_tb.sv
// ----------------------------------------------------------------------------
// energy voice activity detector core testbench
// drives sample frames and control beats over random gaps and stalls, runs a
// cycle-free predictor of the frame energy, hysteresis and calibration, and
// compares every result beat field by field
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_core_tb;
   import evad_pkg::*;

   localparam int FRAME_CAP   = MAX_FRAME_DEF;
   localparam int CAL_COUNT   = CAL_FRAMES_DEF;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE      = 250;
   localparam int PHASE_BEATS = 300;

   typedef struct {
      logic         voiced;
      logic         speech_active;
      activity_type activity;
      logic [15:0]  energy;
      logic [15:0]  threshold;
      logic         calibrating;
   } frame_result_type;

   // predictor of the detector plus the queue of frame results still owed
   class frame_scoreboard_type;
      logic [15:0] init_thr;
      logic [6:0]  cal_gain;
      logic [6:0]  play_gain;
      logic [42:0] sq_sum;
      int unsigned n_samples;
      logic        speech_on;
      logic [3:0]  start_run, end_run, start_need, end_need;
      logic        play_on, cal_on;
      logic [5:0]  cal_count;
      logic [21:0] cal_sum;
      logic [15:0] ambient, base_thr, live_thr;
      frame_result_type owed[$];
      int errors;

      function new();
         init_thr   = INIT_THR_RST;
         cal_gain   = CAL_GAIN_RST;
         play_gain  = PLAY_GAIN_RST;
         sq_sum     = '0;
         n_samples  = 0;
         speech_on  = 1'b0;
         start_run  = '0;
         end_run    = '0;
         start_need = START_NEED_NORMAL;
         end_need   = END_NEED_NORMAL;
         play_on    = 1'b0;
         cal_on     = 1'b0;
         cal_count  = '0;
         cal_sum    = '0;
         ambient    = '0;
         base_thr   = INIT_THR_RST;
         live_thr   = INIT_THR_RST;
         errors     = 0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("mismatch: %s", what);
      endtask

      function logic [6:0] clamp_gain(logic [15:0] v, logic [6:0] lo, logic [6:0] hi);
         logic [6:0] g;
         g = v[6:0];
         return (g < lo) ? lo : ((g > hi) ? hi : g);
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] data);
         case (idx)
            CSR_INIT_THR: begin
               init_thr = data;
               base_thr = data;
               live_thr = data;
            end
            CSR_CAL_GAIN:  cal_gain  = clamp_gain(data, CAL_GAIN_MIN, CAL_GAIN_MAX);
            CSR_PLAY_GAIN: play_gain = clamp_gain(data, PLAY_GAIN_MIN, PLAY_GAIN_MAX);
            default: ;
         endcase
      endfunction

      function longint unsigned int_root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // end of a calibration run: ambient average sets the base threshold
      function void close_calibration();
         int unsigned div, t;
         div = (cal_count == 0) ? 64 : 32'(cal_count);
         ambient = 16'(cal_sum / div);
         t = (32'(ambient) * 32'(cal_gain)) >> 4;
         if (t < 32'(THR_MIN)) t = 32'(THR_MIN);
         if (t > 32'(THR_MAX)) t = 32'(THR_MAX);
         base_thr = 16'(t);
         live_thr = play_on ? 16'((t * 32'(play_gain)) >> 4) : 16'(t);
         cal_on = 1'b0;
      endfunction

      function void take_beat(logic [2:0] mode, logic [15:0] smp, logic last);
         int            sv;
         longint unsigned mag, mean, root;
         int unsigned   t;
         logic [15:0]   energy;
         frame_result_type res;
         case (mode)
            MODE_CAL_START: begin
               cal_on = 1'b1;
               cal_count = '0;
               cal_sum = '0;
               ambient = '0;
               return;
            end
            MODE_PLAY_START: begin
               t = (32'(base_thr) * 32'(play_gain)) >> 4;
               play_on = 1'b1;
               live_thr = (t > 32'(THR_MAX)) ? THR_MAX : 16'(t);
               start_need = START_NEED_PLAY;
               end_need = END_NEED_PLAY;
               return;
            end
            MODE_PLAY_END: begin
               play_on = 1'b0;
               live_thr = base_thr;
               start_need = START_NEED_NORMAL;
               end_need = END_NEED_NORMAL;
               return;
            end
            MODE_CLEAR: begin
               speech_on = 1'b0;
               start_run = '0;
               end_run = '0;
               cal_on = 1'b0;
               cal_count = '0;
               cal_sum = '0;
               ambient = '0;
               live_thr = base_thr;
               sq_sum = '0;
               n_samples = 0;
               return;
            end
            MODE_SAMPLE: ;
            default: return;
         endcase
         if (n_samples < FRAME_CAP) begin
            sv = 32'($signed(smp));
            mag = 64'((sv < 0) ? -sv : sv);
            sq_sum = sq_sum + 43'(mag * mag);
            n_samples++;
         end
         if (!last) return;
         root = 0;
         if (n_samples != 0) begin
            mean = (64'(sq_sum) * 64'd4) / 64'(n_samples);
            root = int_root(mean);
         end
         energy = (root > 65535) ? 16'hFFFF : 16'(root);
         sq_sum = '0;
         n_samples = 0;
         res.voiced = 1'b0;
         res.activity = ACT_NONE;
         if (cal_on) begin
            cal_sum = cal_sum + 22'(energy);
            cal_count = cal_count + 6'd1;
            if (cal_count >= CAL_COUNT || cal_count == 0) close_calibration();
         end else begin
            res.voiced = energy > live_thr;
            if (res.voiced) begin
               end_run = '0;
               if (!speech_on) begin
                  start_run = start_run + 4'd1;
                  if (start_run >= start_need) begin
                     speech_on = 1'b1;
                     start_run = '0;
                     res.activity = ACT_START;
                  end
               end
            end else begin
               start_run = '0;
               if (speech_on) begin
                  end_run = end_run + 4'd1;
                  if (end_run >= end_need) begin
                     speech_on = 1'b0;
                     end_run = '0;
                     res.activity = ACT_END;
                  end
               end
            end
         end
         res.speech_active = speech_on;
         res.energy = energy;
         res.threshold = live_thr;
         res.calibrating = cal_on;
         owed.insert(owed.size(), res);
      endfunction

      task check_result(frame_result_type got);
         frame_result_type want;
         if (owed.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat energy %0d", got.energy));
            return;
         end
         want = owed[0];
         owed.delete(0);
         if (got.voiced !== want.voiced)
            report_mismatch($sformatf("voiced %b want %b", got.voiced, want.voiced));
         if (got.speech_active !== want.speech_active)
            report_mismatch($sformatf("speech_active %b want %b",
                                      got.speech_active, want.speech_active));
         if (got.activity !== want.activity)
            report_mismatch($sformatf("activity %0d want %0d", got.activity, want.activity));
         if (got.energy !== want.energy)
            report_mismatch($sformatf("energy %0d want %0d", got.energy, want.energy));
         if (got.threshold !== want.threshold)
            report_mismatch($sformatf("threshold %0d want %0d", got.threshold, want.threshold));
         if (got.calibrating !== want.calibrating)
            report_mismatch($sformatf("calibrating %b want %b",
                                      got.calibrating, want.calibrating));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_write_data;

   evad_req_if req_chan();
   evad_rsp_if rsp_chan();

   frame_scoreboard_type board;
   int unsigned cycles;
   int unsigned beats_taken;
   bit          send_calm;
   bit          recv_calm;

   energy_voice_activity_detector_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   // mostly short gaps, a few long ones, none during a calm stretch
   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random stalls, every accepted beat goes to the checker
   initial begin
      frame_result_type got;
      int stall;
      stall = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.voiced        = rsp_chan.voiced;
            got.speech_active = rsp_chan.speech_active;
            got.activity      = activity_type'(rsp_chan.activity);
            got.energy        = rsp_chan.energy;
            got.threshold     = rsp_chan.threshold;
            got.calibrating   = rsp_chan.calibrating;
            board.check_result(got);
         end
         if ($urandom_range(0, 299) == 0) recv_calm = ~recv_calm;
         if (stall > 0) begin
            stall--;
            rsp_chan.ready <= (stall == 0);
         end else begin
            stall = pick_gap(recv_calm);
            rsp_chan.ready <= (stall == 0);
         end
      end
   end

   // one request beat; valid stays high across back-to-back beats
   task automatic send_beat(logic [2:0] mode, logic [15:0] smp, logic last);
      int gap;
      if ($urandom_range(0, 199) == 0) send_calm = ~send_calm;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= mode;
      req_chan.sample      <= smp;
      req_chan.last_sample <= last;
      do @(posedge clock); while (!req_chan.ready);
      board.take_beat(mode, smp, last);
      if (mode <= MODE_CLEAR) beats_taken++;
   endtask

   // control beat with junk in the unused fields
   task automatic send_control(mode_type mode);
      send_beat(mode, 16'($urandom), 1'($urandom));
   endtask

   // one frame, loud frames span the full range, quiet ones stay near zero
   task automatic send_frame(int len, bit loud, bit noisy);
      logic [15:0] smp;
      int r;
      for (int k = 0; k < len; k++) begin
         if (loud) smp = 16'($urandom);
         else smp = 16'($urandom_range(0, 400) - 200);
         if (noisy) begin
            r = $urandom_range(0, 99);
            if (r < 2) send_beat(3'($urandom_range(5, 7)), 16'($urandom), 1'($urandom));
            else if (r < 3) send_control(mode_type'($urandom_range(1, 4)));
         end
         send_beat(MODE_SAMPLE, smp, k == len - 1);
      end
   endtask

   // block idle: nothing owed, then room for a beat still in flight
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write enable stays up across a run of writes, the caller drops it
   task automatic write_reg(csr_index_type idx, logic [15:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      board.write_reg(idx, data);
   endtask

   // settings per phase, extremes and out-of-range gains included
   task automatic set_phase_regs(int p);
      logic [15:0] thr, cg, pg;
      case (p % 6)
         0: begin thr = 16'd0;     cg = 16'd0;      pg = 16'hFFFF;  end
         1: begin thr = 16'hFFFF;  cg = 16'hFFFF;   pg = 16'd0;     end
         2: begin thr = THR_MIN; cg = 16'(CAL_GAIN_MIN); pg = 16'(PLAY_GAIN_MAX); end
         3: begin thr = THR_MAX; cg = 16'(CAL_GAIN_MAX); pg = 16'(PLAY_GAIN_MIN); end
         4: begin thr = INIT_THR_RST; cg = 16'($urandom); pg = 16'($urandom); end
         default: begin
            thr = 16'($urandom_range(100, 3000));
            cg = 16'($urandom_range(20, 70));
            pg = 16'($urandom_range(28, 84));
         end
      endcase
      write_reg(CSR_INIT_THR, thr);
      write_reg(CSR_CAL_GAIN, cg);
      write_reg(CSR_PLAY_GAIN, pg);
      csr_write_en <= 1'b0;
   endtask

   // scenes of loud or quiet frames with control beats and unused modes mixed in
   task automatic random_phase(int target);
      int stop, r, run, len;
      bit loud;
      stop = beats_taken + target;
      while (beats_taken < stop) begin
         r = $urandom_range(0, 99);
         if (r < 6) send_control(MODE_CAL_START);
         else if (r < 10) send_control(MODE_PLAY_START);
         else if (r < 13) send_control(MODE_PLAY_END);
         else if (r < 15) send_control(MODE_CLEAR);
         else if (r < 16) send_beat(3'($urandom_range(5, 7)), 16'($urandom), 1'($urandom));
         run = $urandom_range(1, 14);
         loud = $urandom_range(0, 1);
         for (int f = 0; f < run; f++) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                               : $urandom_range(1, 6);
            send_frame(len, loud, 1'b1);
         end
      end
   endtask

   initial begin
      board = new();
      beats_taken = 0;
      send_calm = 1'b0;
      recv_calm = 1'b0;
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= CSR_INIT_THR;
      csr_write_data <= '0;
      req_chan.valid <= 1'b0;
      req_chan.mode <= MODE_SAMPLE;
      req_chan.sample <= '0;
      req_chan.last_sample <= 1'b0;
      rsp_chan.ready <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, every mode, odd frame shapes
      send_beat(MODE_SAMPLE, 16'h7FFF, 1'b1);
      send_beat(MODE_SAMPLE, 16'h8000, 1'b1);
      send_beat(MODE_SAMPLE, 16'h0000, 1'b1);
      send_beat(MODE_SAMPLE, 16'hFFFF, 1'b1);
      send_beat(MODE_SAMPLE, 16'h1234, 1'b0);
      send_control(MODE_PLAY_START);
      send_beat(MODE_SAMPLE, 16'hC000, 1'b1);
      send_beat(3'd5, 16'hFFFF, 1'b1);
      send_beat(3'd6, 16'h0000, 1'b0);
      send_beat(3'd7, 16'h8000, 1'b1);
      send_control(MODE_PLAY_END);
      send_beat(MODE_SAMPLE, 16'h4000, 1'b0);
      send_control(MODE_CLEAR);
      send_beat(MODE_SAMPLE, 16'h0100, 1'b1);
      send_control(MODE_CAL_START);
      for (int k = 0; k < CAL_COUNT; k++) send_beat(MODE_SAMPLE, 16'($urandom), 1'b1);
      send_frame(3, 1'b0, 1'b0);
      drain();

      for (int p = 0; p < 6; p++) begin
         set_phase_regs(p);
         random_phase(PHASE_BEATS);
         drain();
      end

      if (board.pending() != 0) board.report_mismatch("results never arrived");
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/evad_pkg.sv
rtl/evad_req_if.sv
rtl/evad_rsp_if.sv
rtl/evad_divider.sv
rtl/evad_sqrt.sv
rtl/energy_voice_activity_detector_core.sv
rtl/evad_checker.sv
tb/sv/energy_voice_activity_detector_core_tb.sv
